FILE: hdl/bve_pkg.sv
package bve_pkg;

  localparam int DEPTH       = 64;
  localparam int WORD_W      = 32;
  localparam int OPC_W       = 3;
  localparam int POS_W       = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  // compare width, one spare bit so index plus two never wraps
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [OPC_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OPC_W-1:0] OP_POP   = 3'd1;
  localparam logic [OPC_W-1:0] OP_ERASE = 3'd2;
  localparam logic [OPC_W-1:0] OP_CLEAR = 3'd3;
  localparam logic [OPC_W-1:0] OP_READ  = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_CAP,
    S_FRONT,
    S_BACK,
    S_DONE
  } bve_state_t;

  typedef struct packed {
    logic take_in;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic read_cap;
    logic front_rd;
    logic back_rd;
    logic hold_back;
    logic load_out;
  } bve_cmd_t;

  typedef struct packed {
    logic erase_shift;
    logic read_ok;
    logic shift_more;
    logic out_free;
  } bve_stat_t;

endpackage

FILE: hdl/bve_ram.sv
module bve_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/bve_ctrl.sv
module bve_ctrl
  import bve_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  bve_stat_t stat,
  output bve_cmd_t  cmd
);

  bve_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.erase_shift) begin
          state_next = S_SHIFT_RD;
        end else if (stat.read_ok) begin
          state_next = S_READ_CAP;
        end else begin
          state_next = S_FRONT;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        state_next = stat.shift_more ? S_SHIFT_RD : S_FRONT;
      end
      S_READ_CAP: state_next = S_FRONT;
      S_FRONT:    state_next = S_BACK;
      S_BACK:     state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.take_in = in_valid;
      end
      S_EXEC:     cmd.exec     = 1'b1;
      S_SHIFT_RD: cmd.shift_rd = 1'b1;
      S_SHIFT_WR: cmd.shift_wr = 1'b1;
      S_READ_CAP: cmd.read_cap = 1'b1;
      S_FRONT:    cmd.front_rd = 1'b1;
      S_BACK:     cmd.back_rd  = 1'b1;
      S_DONE: begin
        cmd.hold_back = 1'b1;
        cmd.load_out  = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/bve_datapath.sv
module bve_datapath
  import bve_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  bve_cmd_t                   cmd,
  output bve_stat_t                  stat,
  input  logic [OPC_W-1:0]           opcode,
  input  logic signed [WORD_W-1:0]   new_value,
  input  logic [POS_W-1:0]           position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [WORD_W-1:0]   read_value,
  output logic signed [WORD_W-1:0]   front_value,
  output logic signed [WORD_W-1:0]   back_value,
  output logic [COUNT_OUT_W-1:0]     element_count,
  output logic [STATUS_W-1:0]        status
);

  logic [OPC_W-1:0]    op_q;
  logic [WORD_W-1:0]   val_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   k;
  logic [WORD_W-1:0]   rd_res;
  logic [WORD_W-1:0]   front_q;
  logic [STATUS_W-1:0] status_q;

  logic [CMP_W-1:0]  pos_ext, cnt_ext, k_ext;
  logic              pos_in_range, is_full, is_empty;
  logic [ADDR_W-1:0] pos_addr, last_addr, count_addr;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data, rd_data;

  assign pos_ext      = CMP_W'(pos_q);
  assign cnt_ext      = CMP_W'(count);
  assign k_ext        = CMP_W'(k);
  assign pos_in_range = pos_ext < cnt_ext;
  assign is_full      = cnt_ext >= CMP_W'(DEPTH);
  assign is_empty     = count == '0;
  assign pos_addr     = pos_ext[ADDR_W-1:0];
  assign count_addr   = count[ADDR_W-1:0];
  assign last_addr    = ADDR_W'(count - CNT_W'(1));

  assign stat.erase_shift = (op_q == OP_ERASE) && pos_in_range
                            && ((pos_ext + CMP_W'(1)) < cnt_ext);
  assign stat.read_ok     = (op_q == OP_READ) && pos_in_range;
  assign stat.shift_more  = (k_ext + CMP_W'(2)) < cnt_ext;
  assign stat.out_free    = !out_valid || !out_stall;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_addr;
    wr_data = val_q;
    rd_addr = '0;
    if (cmd.exec) begin
      wr_en   = (op_q == OP_PUSH) && !is_full;
      rd_addr = pos_addr;
    end
    if (cmd.shift_rd) begin
      rd_addr = k + ADDR_W'(1);
    end
    if (cmd.shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = k;
      wr_data = rd_data;
    end
    if (cmd.front_rd) begin
      rd_addr = '0;
    end
    if (cmd.back_rd || cmd.hold_back) begin
      rd_addr = last_addr;
    end
  end

  bve_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      op_q  <= opcode;
      val_q <= new_value;
      pos_q <= position;
    end
    if (cmd.exec) begin
      rd_res <= '0;
      k      <= pos_addr;
      unique case (op_q)
        OP_PUSH:  status_q <= is_full ? STAT_FULL : STAT_OK;
        OP_POP:   status_q <= is_empty ? STAT_RANGE : STAT_OK;
        OP_ERASE: status_q <= pos_in_range ? STAT_OK : STAT_RANGE;
        OP_READ:  status_q <= pos_in_range ? STAT_OK : STAT_RANGE;
        default:  status_q <= STAT_OK;
      endcase
    end
    if (cmd.shift_wr) begin
      k <= k + ADDR_W'(1);
    end
    if (cmd.read_cap) begin
      rd_res <= rd_data;
    end
    if (cmd.back_rd) begin
      front_q <= rd_data;
    end
    if (cmd.load_out) begin
      read_value    <= rd_res;
      front_value   <= is_empty ? '0 : front_q;
      back_value    <= is_empty ? '0 : rd_data;
      element_count <= COUNT_OUT_W'(count);
      status        <= status_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        unique case (op_q)
          OP_PUSH:  if (!is_full) count <= count + CNT_W'(1);
          OP_POP:   if (!is_empty) count <= count - CNT_W'(1);
          OP_ERASE: begin
            // last element erased directly, otherwise after the shift
            if (pos_in_range && !stat.erase_shift) count <= count - CNT_W'(1);
          end
          OP_CLEAR: count <= '0;
          default: ;
        endcase
      end
      if (cmd.shift_wr && !stat.shift_more) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/bounded_vector_engine.sv
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  opcode, new_value, position
// out      from block out_valid / out_stall read_value, front_value, back_value,
//                                           element_count, status
//
// push, pop, clear, read and a failed operation pass execute, front, back and done;
// valid read adds a capture, erase of p in n adds n-1-p shift pairs: the registered-read
// element store moves one word per read and write pair, front and back are re-read after
// every operation; result register lets the next transaction enter while one waits
// synchronous rst empties the store; stored words themselves are not cleared
module bounded_vector_engine
  import bve_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPC_W-1:0]         opcode,
  input  logic signed [WORD_W-1:0] new_value,
  input  logic [POS_W-1:0]         position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] read_value,
  output logic signed [WORD_W-1:0] front_value,
  output logic signed [WORD_W-1:0] back_value,
  output logic [COUNT_OUT_W-1:0]   element_count,
  output logic [STATUS_W-1:0]      status
);

  bve_cmd_t  cmd;
  bve_stat_t stat;

  bve_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bve_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (opcode),
    .new_value     (new_value),
    .position      (position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_value    (read_value),
    .front_value   (front_value),
    .back_value    (back_value),
    .element_count (element_count),
    .status        (status)
  );

endmodule

FILE: tb/tb_bounded_vector_engine.sv
module tb_bounded_vector_engine;
  import bve_pkg::*;

  // opcodes the block ignores
  localparam logic [OPC_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OPC_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int TOTAL_ITEMS  = 1850;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 200;
  localparam int MAX_PRINTED  = 40;

  typedef struct {
    logic [OPC_W-1:0]         opcode;
    logic signed [WORD_W-1:0] new_value;
    logic [POS_W-1:0]         position;
    bit                       drain_first;
  } vec_op_t;

  typedef struct {
    logic signed [WORD_W-1:0] read_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [COUNT_OUT_W-1:0]   element_count;
    logic [STATUS_W-1:0]      status;
  } vec_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OPC_W-1:0]         opcode = '0;
  logic signed [WORD_W-1:0] new_value = '0;
  logic [POS_W-1:0]         position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] read_value;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] back_value;
  logic [COUNT_OUT_W-1:0]   element_count;
  logic [STATUS_W-1:0]      status;

  bounded_vector_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .new_value     (new_value),
    .position      (position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_value    (read_value),
    .front_value   (front_value),
    .back_value    (back_value),
    .element_count (element_count),
    .status        (status)
  );

  always #5 clk = ~clk;

  // shadow of the vector contents
  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned              shadow_len = 0;

  vec_op_t     pending_ops[$];
  vec_result_t expected_results[$];

  int plan_len = 0;
  int items_sent = 0;
  int results_done = 0;
  int mismatches = 0;
  int full_hits = 0;
  int range_hits = 0;
  int erase_hits = 0;
  int idle_cycles = 0;

  function automatic vec_result_t apply_vector_op(vec_op_t op);
    vec_result_t r;
    r.read_value = '0;
    r.status     = STAT_OK;
    case (op.opcode)
      OP_PUSH: begin
        if (shadow_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_words[shadow_len] = op.new_value;
          shadow_len++;
        end
      end
      OP_POP: begin
        if (shadow_len == 0) r.status = STAT_RANGE;
        else shadow_len--;
      end
      OP_ERASE: begin
        if (op.position >= shadow_len) begin
          r.status = STAT_RANGE;
        end else begin
          for (int k = op.position; k + 1 < shadow_len; k++)
            shadow_words[k] = shadow_words[k + 1];
          shadow_len--;
          erase_hits++;
        end
      end
      OP_CLEAR: shadow_len = 0;
      OP_READ: begin
        if (op.position >= shadow_len) r.status = STAT_RANGE;
        else r.read_value = shadow_words[op.position];
      end
      default: ;
    endcase
    if (shadow_len == 0) begin
      r.front_value = '0;
      r.back_value  = '0;
    end else begin
      r.front_value = shadow_words[0];
      r.back_value  = shadow_words[shadow_len - 1];
    end
    r.element_count = shadow_len[COUNT_OUT_W-1:0];
    if (r.status == STAT_FULL) full_hits++;
    if (r.status == STAT_RANGE) range_hits++;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (plan_len > 0 && $urandom_range(0, 99) < 85)
      return POS_W'($urandom_range(0, plan_len - 1));
    return POS_W'($urandom_range(0, DEPTH - 1));
  endfunction

  // queues one operation and keeps the planned length in step
  task automatic queue_op(logic [OPC_W-1:0] opc, logic signed [WORD_W-1:0] val,
                          logic [POS_W-1:0] pos);
    vec_op_t op;
    op.opcode      = opc;
    op.new_value   = val;
    op.position    = pos;
    op.drain_first = ($urandom_range(0, 99) == 0) || (pending_ops.size() == 900);
    pending_ops.insert(pending_ops.size(), op);
    case (opc)
      OP_PUSH:  if (plan_len < DEPTH) plan_len++;
      OP_POP:   if (plan_len > 0) plan_len--;
      OP_ERASE: if (pos < plan_len) plan_len--;
      OP_CLEAR: plan_len = 0;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED)
      $display("mismatch, result %0d: %s", results_done, msg);
    mismatches++;
  endtask

  // driver
  vec_op_t cur_op;
  bit      have_item = 1'b0;
  int      sender_gap = 0;
  int      sender_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), apply_vector_op(cur_op));
        items_sent++;
        have_item = 1'b0;
        sender_gap = pick_gap(sender_calm);
      end
      if (!have_item) begin
        if (sender_gap > 0) begin
          sender_gap--;
        end else if (pending_ops.size() > 0 &&
                     (!pending_ops[0].drain_first || items_sent == results_done)) begin
          cur_op = pending_ops.pop_front();
          have_item = 1'b1;
          opcode    <= cur_op.opcode;
          new_value <= cur_op.new_value;
          position  <= cur_op.position;
        end
      end
      in_valid <= have_item;
    end
  end

  // monitor
  int receiver_gap = 0;
  int receiver_calm = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    vec_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction waiting for it");
        end else begin
          want = expected_results.pop_front();
          if (read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h", read_value,
                                      want.read_value));
          if (front_value !== want.front_value)
            report_mismatch($sformatf("front_value %h, expected %h", front_value,
                                      want.front_value));
          if (back_value !== want.back_value)
            report_mismatch($sformatf("back_value %h, expected %h", back_value,
                                      want.back_value));
          if (element_count !== want.element_count)
            report_mismatch($sformatf("element_count %0d, expected %0d", element_count,
                                      want.element_count));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        end
        results_done <= results_done + 1;
        // long hold-offs so the block backs up into its input
        if (results_done + 1 == 250 || results_done + 1 == 1300)
          hold_left = LONG_HOLD;
        else
          receiver_gap = pick_gap(receiver_calm);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (receiver_gap > 0) begin
        receiver_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding", IDLE_LIMIT,
               expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int kind;
    int n;
    int roll;

    // directed: empty store, extremes, every operation, out of range, ignored opcodes
    queue_op(OP_POP, '0, '0);
    queue_op(OP_ERASE, '0, '0);
    queue_op(OP_READ, '0, '0);
    queue_op(OP_CLEAR, '0, '0);
    queue_op(OP_PUSH, 32'sh7fff_ffff, '0);
    queue_op(OP_PUSH, 32'sh8000_0000, '1);
    queue_op(OP_PUSH, '0, '0);
    queue_op(OP_PUSH, -32'sd1, '0);
    queue_op(OP_PUSH, 32'sh5a5a_a5a5, '0);
    queue_op(OP_READ, '0, 6'd0);
    queue_op(OP_READ, '0, 6'd4);
    queue_op(OP_READ, '0, 6'd5);
    queue_op(OP_READ, '0, '1);
    queue_op(OP_ERASE, '0, 6'd2);
    queue_op(OP_ERASE, '0, 6'd3);
    queue_op(OP_ERASE, '0, 6'd0);
    queue_op(OP_READ, '0, 6'd1);
    queue_op(OP_POP, '0, '0);
    queue_op(OP_SPARE_FIRST, -32'sd1, '1);
    queue_op(OP_SPARE_FIRST + 3'd1, 32'sh1234_5678, 6'd1);
    queue_op(OP_SPARE_LAST, '0, '0);
    queue_op(OP_ERASE, '0, '1);
    queue_op(OP_CLEAR, '0, '0);
    queue_op(OP_POP, '0, '0);
    queue_op(OP_PUSH, $urandom, '0);

    // random: fill to capacity and beyond, drain by erase and pop, or a mixed run
    while (pending_ops.size() < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        while (plan_len < DEPTH) begin
          if ($urandom_range(0, 9) == 0) queue_op(OP_READ, pick_value(), pick_position());
          else queue_op(OP_PUSH, pick_value(), pick_position());
        end
        n = $urandom_range(1, 3);
        repeat (n) queue_op(OP_PUSH, pick_value(), pick_position());
      end else if (kind < 5) begin
        n = $urandom_range(10, 40);
        repeat (n) begin
          roll = $urandom_range(0, 9);
          if (roll < 5) queue_op(OP_ERASE, pick_value(), pick_position());
          else if (roll < 8) queue_op(OP_POP, pick_value(), pick_position());
          else queue_op(OP_READ, pick_value(), pick_position());
        end
      end else begin
        n = $urandom_range(20, 60);
        repeat (n) begin
          roll = $urandom_range(0, 99);
          if (roll < 32) queue_op(OP_PUSH, pick_value(), pick_position());
          else if (roll < 44) queue_op(OP_POP, pick_value(), pick_position());
          else if (roll < 62) queue_op(OP_ERASE, pick_value(), pick_position());
          else if (roll < 90) queue_op(OP_READ, pick_value(), pick_position());
          else if (roll < 93) queue_op(OP_CLEAR, pick_value(), pick_position());
          else if (roll < 96)
            queue_op(OPC_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pick_value(),
                     pick_position());
          else
            queue_op(OP_READ, pick_value(), POS_W'($urandom_range(0, DEPTH - 1)));
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_ops.size() != 0 || have_item || items_sent != results_done);
    repeat (TAIL_CYCLES) @(posedge clk);

    while (expected_results.size() > 0) begin
      void'(expected_results.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("%0d operations sent, %0d results checked, %0d mismatches", items_sent,
             results_done, mismatches);
    $display("pushes refused as full: %0d, out of range or empty: %0d, erases: %0d",
             full_hits, range_hits, erase_hits);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bve_pkg.sv
hdl/bve_ram.sv
hdl/bve_ctrl.sv
hdl/bve_datapath.sv
hdl/bounded_vector_engine.sv
tb/tb_bounded_vector_engine.sv
